FILE: design/ebi_pkg.sv
// Package for the Euler body integrator: shared constants and types.
// No dependencies.
package ebi_pkg;
    localparam int WORD_BITS_DEF     = 32;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int CFG_IDX_BITS      = 3;
    localparam int LANES             = 3;

    typedef enum logic [1:0] {
        MODE_FORCE = 2'd0,
        MODE_STEP  = 2'd1,
        MODE_START = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        CFG_MASS  = 3'd0,
        CFG_VLIM  = 3'd1,
        CFG_IVX   = 3'd2,
        CFG_IVY   = 3'd3,
        CFG_IVZ   = 3'd4,
        CFG_IPX   = 3'd5,
        CFG_IPY   = 3'd6,
        CFG_IPZ   = 3'd7
    } t_cfg_idx;

    // Lane command from the sequencer.
    typedef enum logic [2:0] {
        LC_IDLE  = 3'd0,
        LC_DIV   = 3'd1,
        LC_VEL   = 3'd2,
        LC_SCALE = 3'd3,
        LC_POS   = 3'd4
    } t_lane_cmd;

    typedef enum logic [2:0] {
        S_IDLE  = 3'd0,
        S_DIV   = 3'd1,
        S_VEL   = 3'd2,
        S_SQRT  = 3'd3,
        S_SCALE = 3'd4,
        S_POS   = 3'd5,
        S_OUT   = 3'd6
    } t_state;
endpackage

FILE: design/ebi_lane.sv
// One axis of the integrator: holds force, acceleration, velocity, position and
// a shared bit-serial divider used for F/mass and for the clamp scaling. Uses ebi_pkg.
module ebi_lane #(
    parameter int WORD_BITS     = ebi_pkg::WORD_BITS_DEF,
    parameter int FRACTION_BITS = ebi_pkg::FRACTION_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  ebi_pkg::t_lane_cmd       i_cmd,
    input  logic                     i_start,
    input  logic                     i_add_force,
    input  logic                     i_load,
    input  logic                     i_zero_vel,
    input  logic signed [WORD_BITS-1:0] i_force,
    input  logic signed [WORD_BITS-1:0] i_init_vel,
    input  logic signed [WORD_BITS-1:0] i_init_pos,
    input  logic [15:0]              i_dt,
    input  logic [WORD_BITS-1:0]     i_den,
    input  logic [WORD_BITS-2:0]     i_limit,
    output logic signed [WORD_BITS-1:0] o_vel,
    output logic signed [WORD_BITS-1:0] o_pos
);
    import ebi_pkg::*;

    localparam int NB = 2 * WORD_BITS;
    localparam int CB = $clog2(NB + 1);
    localparam logic signed [NB:0] WMAX = (NB+1)'((64'sd1 <<< (WORD_BITS-1)) - 1);
    localparam logic signed [NB:0] WMIN = -WMAX - 1;

    logic signed [WORD_BITS-1:0] r_f, r_a, r_v, r_p;
    logic [NB-1:0] r_q, r_num;
    logic [NB:0]   r_rem;
    logic          r_neg;
    logic [CB-1:0] r_cnt;
    logic          r_is_div;

    function automatic logic signed [WORD_BITS-1:0] sat(input logic signed [NB:0] x);
        if (x > WMAX) return WMAX[WORD_BITS-1:0];
        if (x < WMIN) return WMIN[WORD_BITS-1:0];
        return x[WORD_BITS-1:0];
    endfunction

    // (x*dt) >> FRACTION_BITS toward zero, one multiplier.
    function automatic logic signed [NB:0] mul_dt(input logic signed [WORD_BITS-1:0] x,
                                                   input logic [15:0] dt);
        logic signed [WORD_BITS+17:0] p;
        logic [WORD_BITS+17:0] m;
        p = x * $signed({1'b0, dt});
        m = p[WORD_BITS+17] ? -p : p;
        m = m >> FRACTION_BITS;
        return p[WORD_BITS+17] ? -(NB+1)'(m) : (NB+1)'(m);
    endfunction

    logic [NB-1:0] div_mag;
    logic [NB:0]   trial;
    logic signed [NB-1:0] prod;
    assign prod = (i_cmd == LC_DIV) ? (NB)'(r_f) <<< FRACTION_BITS
                                    : (NB)'(r_v) * $signed({1'b0, i_limit});
    assign div_mag = prod[NB-1] ? -prod : prod;
    assign trial = {r_rem[NB-1:0], r_num[NB-1]} - {1'b0, (NB)'(i_den)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f <= '0; r_a <= '0; r_v <= '0; r_p <= '0; r_cnt <= '0; r_is_div <= 1'b0;
        end else begin
            if (i_add_force) r_f <= sat((NB+1)'(r_f) + (NB+1)'(i_force));
            if (i_load) begin
                r_v <= i_init_vel; r_p <= i_init_pos; r_f <= '0;
            end
            if (i_start && (i_cmd == LC_DIV || i_cmd == LC_SCALE)) begin
                r_num <= div_mag; r_neg <= prod[NB-1]; r_rem <= '0; r_q <= '0;
                r_cnt <= CB'(NB); r_is_div <= (i_cmd == LC_DIV);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                r_num <= r_num << 1;
                if (!trial[NB]) begin
                    r_rem <= trial; r_q <= {r_q[NB-2:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[NB-1:0], r_num[NB-1]}; r_q <= {r_q[NB-2:0], 1'b0};
                end
                if (r_cnt == CB'(1)) begin
                    if (r_is_div) r_a <= sat(r_neg ? -$signed({1'b0, r_q[NB-2:0], !trial[NB]})
                                                   :  $signed({1'b0, r_q[NB-2:0], !trial[NB]}));
                    else r_v <= sat(r_neg ? -$signed({1'b0, r_q[NB-2:0], !trial[NB]})
                                          :  $signed({1'b0, r_q[NB-2:0], !trial[NB]}));
                end
            end
            if (i_zero_vel) r_v <= '0;
            else if (i_start && i_cmd == LC_VEL) r_v <= sat((NB+1)'(r_v) + mul_dt(r_a, i_dt));
            if (i_start && i_cmd == LC_POS) begin
                r_p <= sat((NB+1)'(r_p) + mul_dt(r_v, i_dt));
                r_f <= '0;
            end
        end
    end

    assign o_vel = r_v;
    assign o_pos = r_p;
endmodule

FILE: design/ebi_merge.sv
// Merging stage: squares of the three lane velocities, compares against limit^2
// and takes an iterative integer square root. Uses ebi_pkg.
module ebi_merge #(
    parameter int WORD_BITS = ebi_pkg::WORD_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic signed [WORD_BITS-1:0] i_vx,
    input  logic signed [WORD_BITS-1:0] i_vy,
    input  logic signed [WORD_BITS-1:0] i_vz,
    input  logic [WORD_BITS-2:0]        i_limit,
    output logic                        o_busy,
    output logic                        o_over,
    output logic [WORD_BITS-1:0]        o_root
);
    import ebi_pkg::*;

    localparam int NB = 2 * WORD_BITS;
    localparam int CB = $clog2(WORD_BITS + 3);

    logic [NB+1:0] r_x, r_r, r_bit;
    logic [CB-1:0] r_cnt;
    logic [1:0]    r_ph;
    logic [NB-1:0] r_sq0, r_sq1, r_sq2;
    logic          r_over;

    logic [NB+1:0] sum, lim2, cand;
    assign sum  = (NB+2)'(r_sq0) + (NB+2)'(r_sq1) + (NB+2)'(r_sq2);
    assign lim2 = (NB+2)'(i_limit) * (NB+2)'(i_limit);
    assign cand = r_r + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= '0; r_cnt <= '0; r_over <= 1'b0;
        end else if (i_start) begin
            r_sq0 <= NB'(i_vx * i_vx); r_sq1 <= NB'(i_vy * i_vy); r_sq2 <= NB'(i_vz * i_vz);
            r_ph <= 2'd1;
        end else if (r_ph == 2'd1) begin
            // The sum of squares wraps at 2*WORD_BITS bits.
            r_x    <= (NB+2)'(sum[NB-1:0]);
            r_over <= (NB+2)'(sum[NB-1:0]) > lim2;
            r_r    <= '0;
            r_bit  <= (NB+2)'(1) << (NB - 2);
            r_cnt  <= CB'(WORD_BITS);
            r_ph   <= 2'd2;
        end else if (r_ph == 2'd2) begin
            if (r_x >= cand) begin
                r_x <= r_x - cand; r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CB'(1)) r_ph <= 2'd0;
        end
    end

    assign o_busy = (r_ph != 2'd0) || i_start;
    assign o_over = r_over;
    assign o_root = r_r[WORD_BITS-1:0];
endmodule

FILE: design/euler_body_integrator.sv
// Top level of the Euler body integrator: configuration registers, sequencer,
// three axis lanes and the magnitude merge stage. Uses ebi_pkg, ebi_lane, ebi_merge.
//
// One transaction in, one out; a new input is taken only after the previous result
// has been taken. Force, start and idle transactions load the result register at the
// accepting edge. A time step runs, in order, the bit-serial division F/mass, the
// velocity update, the squares and the one-bit-per-cycle square root in the merge
// stage, the bit-serial clamp scaling of the velocity, the position update and the
// output. Without an over-limit velocity the scaling is skipped, a zero limit skips
// root and scaling, and a zero mass skips the division. The result register holds
// until taken.
module euler_body_integrator #(
    parameter int WORD_BITS     = ebi_pkg::WORD_BITS_DEF,
    parameter int FRACTION_BITS = ebi_pkg::FRACTION_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [ebi_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [WORD_BITS-1:0]        i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_mode,
    input  logic signed [WORD_BITS-1:0] i_force_x,
    input  logic signed [WORD_BITS-1:0] i_force_y,
    input  logic signed [WORD_BITS-1:0] i_force_z,
    input  logic [15:0]                 i_delta_time,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [WORD_BITS-1:0] o_position_x,
    output logic signed [WORD_BITS-1:0] o_position_y,
    output logic signed [WORD_BITS-1:0] o_position_z,
    output logic signed [WORD_BITS-1:0] o_velocity_x,
    output logic signed [WORD_BITS-1:0] o_velocity_y,
    output logic signed [WORD_BITS-1:0] o_velocity_z
);
    import ebi_pkg::*;

    localparam int NB = 2 * WORD_BITS;
    localparam int CB = $clog2(NB + 3);

    logic [WORD_BITS-1:0] r_mass, r_iv [LANES], r_ip [LANES];
    logic [WORD_BITS-2:0] r_vlim;
    t_state r_state, n_state;
    logic [CB-1:0] r_wait, n_wait;
    logic [15:0]   r_dt;
    logic          r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mass <= WORD_BITS'(1) << FRACTION_BITS;
            r_vlim <= '1;
            for (int i = 0; i < LANES; i++) begin
                r_iv[i] <= '0; r_ip[i] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_MASS: r_mass <= i_cfg_data;
                CFG_VLIM: r_vlim <= i_cfg_data[WORD_BITS-2:0];
                CFG_IVX:  r_iv[0] <= i_cfg_data;
                CFG_IVY:  r_iv[1] <= i_cfg_data;
                CFG_IVZ:  r_iv[2] <= i_cfg_data;
                CFG_IPX:  r_ip[0] <= i_cfg_data;
                CFG_IPY:  r_ip[1] <= i_cfg_data;
                CFG_IPZ:  r_ip[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic accept;
    assign o_stall = (r_state != S_IDLE) || r_ovalid;
    assign accept  = i_valid && !o_stall;

    logic merge_busy, merge_over;
    logic [WORD_BITS-1:0] root;
    logic signed [WORD_BITS-1:0] vel [LANES], pos [LANES];

    always_comb begin
        n_state = r_state;
        n_wait  = r_wait;
        unique case (r_state)
            S_IDLE: if (accept && t_mode'(i_mode) == MODE_STEP) begin
                n_state = (r_mass != '0) ? S_DIV : S_VEL;
                n_wait  = CB'(NB + 1);
            end
            S_DIV: begin
                n_wait = r_wait - 1'b1;
                if (r_wait == CB'(1)) n_state = S_VEL;
            end
            S_VEL: begin
                n_state = (r_vlim == '0) ? S_POS : S_SQRT;
                n_wait  = CB'(1);
            end
            S_SQRT: begin
                n_wait = '0;
                if (r_wait == '0 && !merge_busy) begin
                    n_state = merge_over ? S_SCALE : S_POS;
                    n_wait  = CB'(NB + 1);
                end
            end
            S_SCALE: begin
                n_wait = r_wait - 1'b1;
                if (r_wait == CB'(1)) n_state = S_POS;
            end
            S_POS:   n_state = S_OUT;
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    t_lane_cmd cmd;
    logic lane_start, merge_start, zero_vel;
    always_comb begin
        cmd = LC_IDLE; lane_start = 1'b0; merge_start = 1'b0; zero_vel = 1'b0;
        unique case (r_state)
            S_DIV:   begin cmd = LC_DIV; lane_start = (r_wait == CB'(NB + 1)); end
            S_VEL:   begin
                cmd = LC_VEL; lane_start = 1'b1; zero_vel = 1'b0;
            end
            S_SQRT:  begin cmd = LC_IDLE; merge_start = (r_wait == CB'(1)); end
            S_SCALE: begin cmd = LC_SCALE; lane_start = (r_wait == CB'(NB + 1)); end
            S_POS:   begin cmd = LC_POS; lane_start = 1'b1; zero_vel = 1'b0; end
            default: ;
        endcase
    end

    // A zero limit forces velocity to zero in place of the velocity update.
    logic vel_zero;
    assign vel_zero = (r_state == S_VEL) && (r_vlim == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_wait <= '0; r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wait  <= n_wait;
            if (accept && t_mode'(i_mode) != MODE_STEP) r_ovalid <= 1'b1;
            else if (r_state == S_OUT) r_ovalid <= 1'b1;
            else if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_dt <= i_delta_time;
    end

    logic signed [WORD_BITS-1:0] force_in [LANES];
    assign force_in[0] = i_force_x;
    assign force_in[1] = i_force_y;
    assign force_in[2] = i_force_z;

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        logic vz;
        assign vz = vel_zero;
        ebi_lane #(.WORD_BITS(WORD_BITS), .FRACTION_BITS(FRACTION_BITS)) u_lane (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_cmd(cmd), .i_start(lane_start),
            .i_add_force(accept && t_mode'(i_mode) == MODE_FORCE),
            .i_load(accept && t_mode'(i_mode) == MODE_START),
            .i_zero_vel(vz || zero_vel),
            .i_force(force_in[g]), .i_init_vel(r_iv[g]), .i_init_pos(r_ip[g]),
            .i_dt(r_dt),
            .i_den((cmd == LC_DIV) ? r_mass : root),
            .i_limit(r_vlim),
            .o_vel(vel[g]), .o_pos(pos[g])
        );
    end

    ebi_merge #(.WORD_BITS(WORD_BITS)) u_merge (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(merge_start),
        .i_vx(vel[0]), .i_vy(vel[1]), .i_vz(vel[2]), .i_limit(r_vlim),
        .o_busy(merge_busy), .o_over(merge_over), .o_root(root)
    );

    assign o_valid = r_ovalid;
    assign o_position_x = pos[0];
    assign o_position_y = pos[1];
    assign o_position_z = pos[2];
    assign o_velocity_x = vel[0];
    assign o_velocity_y = vel[1];
    assign o_velocity_z = vel[2];
endmodule
